// ===== design/stpt_pkg.sv =====
// Shared types, constants and the arctangent table of the Stanley steering block.
`timescale 1ns / 1ps
package stpt_pkg;

    // Datapath widths
    localparam int CORDIC_W = 52;
    localparam int ANG_W    = 35;
    localparam int DIFF_W   = 33;
    localparam int PROD_W   = 66;
    localparam int SC_W     = 17;
    localparam int TR_W     = 13;
    localparam int SPD_W    = 14;

    typedef logic signed [ANG_W-1:0]    angle_t;
    typedef logic signed [CORDIC_W-1:0] cvec_t;

    // Angles are Q5.29 radians
    localparam angle_t Q_PI      = 35'sd1686629713;
    localparam angle_t Q_HALF_PI = 35'sd843314857;
    localparam angle_t Q_TWO_PI  = 35'sd3373259426;
    localparam angle_t Q_SAT     = 35'sd322122547;
    localparam cvec_t  CORDIC_K  = 52'sd652032875;
    localparam cvec_t  K_LINVEL  = 52'sd161061274;

    // Input commands
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // Result status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;

    // Configuration register byte addresses
    localparam logic [1:0] REG_CRUISE = 2'd0;

    typedef enum logic {
        CM_VECTOR,
        CM_ROTATE
    } cordic_mode_t;

    typedef struct packed {
        logic         start;
        cordic_mode_t mode;
    } cordic_req_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SC_RD,
        ST_SC_DAT,
        ST_SC_MX,
        ST_SC_MY,
        ST_SEL,
        ST_SEG_RD,
        ST_SEG_DAT,
        ST_NX_RD,
        ST_NX_DAT,
        ST_YAW_GO,
        ST_YAW_WAIT,
        ST_HW1,
        ST_HW2,
        ST_SIN_GO,
        ST_SIN_WAIT,
        ST_E_MX,
        ST_E_MY,
        ST_TD_GO,
        ST_TD_WAIT,
        ST_TE1,
        ST_TE2,
        ST_W1,
        ST_W2,
        ST_SP,
        ST_SQ_WAIT,
        ST_OUT
    } stpt_state_t;

    // Elementary arctangent angles atan(2^-i) in Q5.29
    function automatic angle_t atan_entry(input logic [4:0] idx);
        angle_t r;
        case (idx)
            5'd0:    r = 35'sd421657428;
            5'd1:    r = 35'sd248918915;
            5'd2:    r = 35'sd131521918;
            5'd3:    r = 35'sd66762579;
            5'd4:    r = 35'sd33510843;
            5'd5:    r = 35'sd16771757;
            5'd6:    r = 35'sd8387925;
            5'd7:    r = 35'sd4194219;
            5'd8:    r = 35'sd2097141;
            5'd9:    r = 35'sd1048575;
            5'd10:   r = 35'sd524288;
            5'd11:   r = 35'sd262144;
            5'd12:   r = 35'sd131072;
            5'd13:   r = 35'sd65536;
            5'd14:   r = 35'sd32768;
            5'd15:   r = 35'sd16384;
            5'd16:   r = 35'sd8192;
            5'd17:   r = 35'sd4096;
            5'd18:   r = 35'sd2048;
            5'd19:   r = 35'sd1024;
            5'd20:   r = 35'sd512;
            5'd21:   r = 35'sd256;
            5'd22:   r = 35'sd128;
            5'd23:   r = 35'sd64;
            default: r = '0;
        endcase
        return r;
    endfunction

    // One pass of wrapping an angle into [-pi, pi]
    function automatic angle_t wrap_once(input angle_t a);
        angle_t r;
        r = a;
        if (r > Q_PI) r = r - Q_TWO_PI;
        if (r < -Q_PI) r = r + Q_TWO_PI;
        return r;
    endfunction

endpackage

// ===== design/stpt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module stpt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/stpt_cordic.sv =====
// Iterative CORDIC unit, vectoring (atan2) or rotation (sin and cos), one step a cycle.
`timescale 1ns / 1ps
module stpt_cordic #(
    parameter int STEPS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  stpt_pkg::cordic_req_t                 req,
    input  logic signed [stpt_pkg::CORDIC_W-1:0]  x_in,
    input  logic signed [stpt_pkg::CORDIC_W-1:0]  y_in,
    input  logic signed [stpt_pkg::ANG_W-1:0]     z_in,
    output logic                                  busy,
    output logic signed [stpt_pkg::CORDIC_W-1:0]  x_out,
    output logic signed [stpt_pkg::CORDIC_W-1:0]  y_out,
    output logic signed [stpt_pkg::ANG_W-1:0]     z_out
);
    import stpt_pkg::*;

    localparam int ITW = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic             busy_reg;
    logic [ITW-1:0]   it_reg;
    cordic_mode_t     mode_reg;
    logic             neg_reg;
    cvec_t            x_reg;
    cvec_t            y_reg;
    angle_t           z_reg;

    cvec_t            xs;
    cvec_t            ys;
    angle_t           step_ang;
    logic             vec_zero;
    logic             fold_hi;
    logic             fold_lo;

    assign xs       = x_reg >>> it_reg;
    assign ys       = y_reg >>> it_reg;
    assign step_ang = atan_entry(5'(it_reg));
    assign vec_zero = (x_in == '0) && (y_in == '0);
    assign fold_hi  = z_in > Q_HALF_PI;
    assign fold_lo  = z_in < -Q_HALF_PI;

    // Sequencing of the iterations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            it_reg   <= '0;
            mode_reg <= CM_VECTOR;
            neg_reg  <= 1'b0;
        end
        else if (req.start)
        begin
            busy_reg <= !((req.mode == CM_VECTOR) && vec_zero);
            it_reg   <= '0;
            mode_reg <= req.mode;
            neg_reg  <= (req.mode == CM_ROTATE) && (fold_hi || fold_lo);
        end
        else if (busy_reg)
        begin
            if (it_reg == ITW'(STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                it_reg <= it_reg + 1'b1;
            end
        end
    end

    // Vector and angle registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            if (req.mode == CM_VECTOR)
            begin
                if (vec_zero)
                begin
                    x_reg <= x_in;
                    y_reg <= y_in;
                    z_reg <= '0;
                end
                else if (x_in < 0)
                begin
                    x_reg <= -x_in;
                    y_reg <= -y_in;
                    z_reg <= (y_in >= 0) ? Q_PI : -Q_PI;
                end
                else
                begin
                    x_reg <= x_in;
                    y_reg <= y_in;
                    z_reg <= '0;
                end
            end
            else
            begin
                x_reg <= CORDIC_K;
                y_reg <= '0;
                if (fold_hi)
                begin
                    z_reg <= z_in - Q_PI;
                end
                else if (fold_lo)
                begin
                    z_reg <= z_in + Q_PI;
                end
                else
                begin
                    z_reg <= z_in;
                end
            end
        end
        else if (busy_reg)
        begin
            if (mode_reg == CM_VECTOR)
            begin
                if (y_reg >= 0)
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + step_ang;
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - step_ang;
                end
            end
            else
            begin
                if (z_reg >= 0)
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - step_ang;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + step_ang;
                end
            end
        end
    end

    // A folded rotation angle flips the final vector
    assign busy  = busy_reg;
    assign x_out = neg_reg ? -x_reg : x_reg;
    assign y_out = neg_reg ? -y_reg : y_reg;
    assign z_out = z_reg;

endmodule

// ===== design/stpt_isqrt.sv =====
// Bit-serial integer square root of a 64-bit value, one result bit a cycle.
`timescale 1ns / 1ps
module stpt_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        busy,
    output logic [31:0] root
);

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] rad_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;

    logic [35:0] rem4;
    logic [35:0] trial;
    logic        take;

    assign rem4  = {rem_reg, rad_reg[63:62]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign take  = rem4 >= trial;

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd31)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 6'd1;
            end
        end
    end

    // Restoring digit recurrence, two radicand bits per step
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[61:0], 2'b00};
            if (take)
            begin
                rem_reg  <= 34'(rem4 - trial);
                root_reg <= {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem4[33:0];
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// ===== design/stanley_path_tracking_steer_top.sv =====
// Top level of the Stanley path-tracking steering block: path store, sequencer and datapath.
//
//   Channel   Direction  Handshake            Beat contents
//   in        sink       in_valid / in_stall  command, pos_x, pos_y, heading
//   out       source     out_valid / out_stall status, turn_rate, linear_speed,
//                                             nearest_distance, path_ended
//   config    APB slave  psel / penable       cruise_speed at byte address 0
//
// A pose query scans every remaining path point for the nearest one (one shared
// multiplier squares both offsets), then uses the shared CORDIC unit for the segment
// heading, sin/cos and the cross-track angle, with the square root overlapped; the
// segment heading pass is skipped when a single point remains.
// Reset empties the path; the path store itself is not cleared.
// A new beat is taken only in idle; a finished result waits in ST_OUT until the output register is free.
`timescale 1ns / 1ps
module stanley_path_tracking_steer_top #(
    parameter int PATH_DEPTH   = 256,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [14:0] heading,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [12:0] turn_rate,
    output logic [13:0]        linear_speed,
    output logic [31:0]        nearest_distance,
    output logic               path_ended,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import stpt_pkg::*;

    localparam int AW = $clog2(PATH_DEPTH);
    localparam int NW = $clog2(PATH_DEPTH + 1);

    // Ring address addition modulo the store depth
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(PATH_DEPTH)) s = s - (AW+1)'(PATH_DEPTH);
        return s[AW-1:0];
    endfunction

    stpt_state_t state_reg;
    stpt_state_t state_next;

    logic [AW-1:0]  head_reg;
    logic [NW-1:0]  count_reg;
    logic [13:0]    cruise_reg;
    logic           out_valid_reg;

    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;
    angle_t             ang_reg;
    logic [NW-1:0]      idx_reg;
    logic [NW-1:0]      best_reg;
    logic [64:0]        best_sum_reg;
    logic [31:0]        ax_reg;
    logic [31:0]        ay_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DIFF_W-1:0] sx_reg;
    logic signed [DIFF_W-1:0] sy_reg;
    logic signed [DIFF_W-1:0] dx_reg;
    logic signed [DIFF_W-1:0] dy_reg;
    logic signed [DIFF_W-1:0] vx_reg;
    logic signed [DIFF_W-1:0] vy_reg;
    angle_t             cyaw_reg;
    logic signed [SC_W-1:0] s_reg;
    logic signed [SC_W-1:0] c_reg;
    cvec_t              e_reg;
    angle_t             td_reg;
    angle_t             te_reg;
    logic signed [36:0] half_reg;
    logic signed [37:0] quarter_reg;
    logic signed [TR_W-1:0] tr_reg;

    logic [1:0]         res_status_reg;
    logic signed [TR_W-1:0] res_tr_reg;
    logic [SPD_W-1:0]   res_sp_reg;
    logic [31:0]        res_dist_reg;
    logic               res_pe_reg;

    logic [1:0]         status_reg;
    logic signed [TR_W-1:0] turn_rate_reg;
    logic [SPD_W-1:0]   linear_speed_reg;
    logic [31:0]        nearest_distance_reg;
    logic               path_ended_reg;

    // Combinational controls from the sequencer
    logic               accept;
    logic               out_load;
    logic [AW-1:0]      ram_raddr;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [63:0]        ram_rdata;
    logic signed [DIFF_W-1:0] mul_a;
    logic signed [DIFF_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    cordic_req_t        cor_req;
    cvec_t              cor_x_in;
    cvec_t              cor_y_in;
    angle_t             cor_z_in;
    logic               cor_busy;
    cvec_t              cor_x_out;
    cvec_t              cor_y_out;
    angle_t             cor_z_out;
    logic               isq_start;
    logic               isq_busy;
    logic [31:0]        isq_root;

    logic               store_full;
    logic [NW-1:0]      count_after;
    logic signed [DIFF_W-1:0] ram_x;
    logic signed [DIFF_W-1:0] ram_y;
    logic signed [DIFF_W-1:0] ddx;
    logic signed [DIFF_W-1:0] ddy;
    logic [64:0]        sq_sum;
    logic [NW-1:0]      idx_inc;

    assign accept     = in_valid && !in_stall;
    assign out_load   = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);
    assign store_full = count_reg == NW'(PATH_DEPTH);
    assign ram_x      = DIFF_W'($signed(ram_rdata[31:0]));
    assign ram_y      = DIFF_W'($signed(ram_rdata[63:32]));
    assign ddx        = ram_x - DIFF_W'(px_reg);
    assign ddy        = ram_y - DIFF_W'(py_reg);
    assign mul_p      = mul_a * mul_b;
    assign sq_sum     = {1'b0, prod_reg[63:0]} + {1'b0, mul_p[63:0]};
    assign idx_inc    = idx_reg + 1'b1;
    assign ram_we     = accept && (command == CMD_APPEND) && !store_full;
    assign ram_waddr  = ring_add(head_reg, count_reg[AW-1:0]);

    // Path count as it stands after a clear or append beat
    always_comb
    begin
        case (command)
            CMD_CLEAR:  count_after = '0;
            CMD_APPEND: count_after = store_full ? count_reg : count_reg + 1'b1;
            default:    count_after = count_reg;
        endcase
    end

    // Path store: x in the low word, y in the high word
    stpt_ram #(
        .WIDTH (64),
        .DEPTH (PATH_DEPTH)
    ) u_path_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({pos_y, pos_x}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared CORDIC for segment heading, sin/cos and the cross-track angle
    stpt_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cor_req),
        .x_in  (cor_x_in),
        .y_in  (cor_y_in),
        .z_in  (cor_z_in),
        .busy  (cor_busy),
        .x_out (cor_x_out),
        .y_out (cor_y_out),
        .z_out (cor_z_out)
    );

    // Square root of the nearest squared distance
    stpt_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (isq_start),
        .radicand (best_sum_reg[63:0]),
        .busy     (isq_busy),
        .root     (isq_root)
    );

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((command == CMD_QUERY) && (count_reg != '0))
                        state_next = ST_SC_RD;
                    else
                        state_next = ST_OUT;
                end
            end
            ST_SC_RD:    state_next = ST_SC_DAT;
            ST_SC_DAT:   state_next = ST_SC_MX;
            ST_SC_MX:    state_next = ST_SC_MY;
            ST_SC_MY:    state_next = (idx_inc == count_reg) ? ST_SEL : ST_SC_RD;
            ST_SEL:      state_next = ST_SEG_RD;
            ST_SEG_RD:   state_next = ST_SEG_DAT;
            ST_SEG_DAT:  state_next = (count_reg >= NW'(2)) ? ST_NX_RD : ST_HW1;
            ST_NX_RD:    state_next = ST_NX_DAT;
            ST_NX_DAT:   state_next = ST_YAW_GO;
            ST_YAW_GO:   state_next = ST_YAW_WAIT;
            ST_YAW_WAIT: state_next = cor_busy ? ST_YAW_WAIT : ST_HW1;
            ST_HW1:      state_next = ST_HW2;
            ST_HW2:      state_next = ST_SIN_GO;
            ST_SIN_GO:   state_next = ST_SIN_WAIT;
            ST_SIN_WAIT: state_next = cor_busy ? ST_SIN_WAIT : ST_E_MX;
            ST_E_MX:     state_next = ST_E_MY;
            ST_E_MY:     state_next = ST_TD_GO;
            ST_TD_GO:    state_next = ST_TD_WAIT;
            ST_TD_WAIT:  state_next = cor_busy ? ST_TD_WAIT : ST_TE1;
            ST_TE1:      state_next = ST_TE2;
            ST_TE2:      state_next = ST_W1;
            ST_W1:       state_next = ST_W2;
            ST_W2:       state_next = ST_SP;
            ST_SP:       state_next = ST_SQ_WAIT;
            ST_SQ_WAIT:  state_next = isq_busy ? ST_SQ_WAIT : ST_OUT;
            ST_OUT:      state_next = out_load ? ST_IDLE : ST_OUT;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: memory address, multiplier operands, unit starts
    always_comb
    begin
        in_stall  = 1'b1;
        ram_raddr = head_reg;
        mul_a     = '0;
        mul_b     = '0;
        cor_req   = '{start: 1'b0, mode: CM_VECTOR};
        cor_x_in  = '0;
        cor_y_in  = '0;
        cor_z_in  = '0;
        isq_start = 1'b0;
        case (state_reg)
            ST_IDLE:  in_stall = 1'b0;
            ST_SC_RD: ram_raddr = ring_add(head_reg, idx_reg[AW-1:0]);
            ST_SC_MX:
            begin
                mul_a = $signed({1'b0, ax_reg});
                mul_b = $signed({1'b0, ax_reg});
            end
            ST_SC_MY:
            begin
                mul_a = $signed({1'b0, ay_reg});
                mul_b = $signed({1'b0, ay_reg});
            end
            ST_SEL:   isq_start = 1'b1;
            ST_NX_RD: ram_raddr = ring_add(head_reg, AW'(1));
            ST_YAW_GO:
            begin
                cor_req  = '{start: 1'b1, mode: CM_VECTOR};
                cor_x_in = CORDIC_W'(vx_reg);
                cor_y_in = CORDIC_W'(vy_reg);
            end
            ST_SIN_GO:
            begin
                cor_req  = '{start: 1'b1, mode: CM_ROTATE};
                cor_z_in = ang_reg;
            end
            ST_E_MX:
            begin
                mul_a = dx_reg;
                mul_b = DIFF_W'(s_reg);
            end
            ST_E_MY:
            begin
                mul_a = dy_reg;
                mul_b = DIFF_W'(c_reg);
            end
            ST_TD_GO:
            begin
                cor_req  = '{start: 1'b1, mode: CM_VECTOR};
                cor_x_in = K_LINVEL;
                cor_y_in = e_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Path window bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (accept && (command == CMD_CLEAR))
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (ram_we)
        begin
            count_reg <= count_reg + 1'b1;
        end
        else if (state_reg == ST_SEL)
        begin
            head_reg  <= ring_add(head_reg, best_reg[AW-1:0]);
            count_reg <= count_reg - best_reg;
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cruise_reg <= 14'd287;
        else if (psel && penable && pwrite)
            cruise_reg <= pwdata[13:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_CRUISE) ? {18'd0, cruise_reg} : 32'd0;

    // Query datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    px_reg  <= pos_x;
                    py_reg  <= pos_y;
                    ang_reg <= angle_t'($signed({heading, 17'd0}));
                    idx_reg <= '0;
                    res_tr_reg   <= '0;
                    res_sp_reg   <= '0;
                    res_dist_reg <= '0;
                    if (command == CMD_QUERY)
                    begin
                        res_status_reg <= (count_reg == '0) ? STS_EMPTY : STS_OK;
                        res_pe_reg     <= count_reg < NW'(3);
                    end
                    else
                    begin
                        res_status_reg <= ((command == CMD_APPEND) && store_full) ?
                                          STS_FULL : STS_OK;
                        res_pe_reg     <= count_after < NW'(3);
                    end
                end
            end
            ST_SC_DAT:
            begin
                ax_reg <= ddx[DIFF_W-1] ? 32'(-ddx) : ddx[31:0];
                ay_reg <= ddy[DIFF_W-1] ? 32'(-ddy) : ddy[31:0];
            end
            ST_SC_MX: prod_reg <= mul_p;
            ST_SC_MY:
            begin
                if ((idx_reg == '0) || (sq_sum < best_sum_reg))
                begin
                    best_sum_reg <= sq_sum;
                    best_reg     <= idx_reg;
                end
                idx_reg <= idx_inc;
            end
            ST_SEG_DAT:
            begin
                sx_reg   <= ram_x;
                sy_reg   <= ram_y;
                dx_reg   <= DIFF_W'(px_reg) - ram_x;
                dy_reg   <= DIFF_W'(py_reg) - ram_y;
                cyaw_reg <= '0;
            end
            ST_NX_DAT:
            begin
                vx_reg <= ram_x - sx_reg;
                vy_reg <= ram_y - sy_reg;
            end
            ST_YAW_WAIT: cyaw_reg <= cor_z_out;
            ST_HW1, ST_HW2: ang_reg <= wrap_once(ang_reg);
            ST_SIN_WAIT:
            begin
                c_reg <= SC_W'((cor_x_out + cvec_t'(32768)) >>> 16);
                s_reg <= SC_W'((cor_y_out + cvec_t'(32768)) >>> 16);
            end
            ST_E_MX:   prod_reg <= mul_p;
            ST_E_MY:   e_reg <= CORDIC_W'(prod_reg - mul_p);
            ST_TD_WAIT:
            begin
                td_reg <= cor_z_out;
                te_reg <= cyaw_reg - ang_reg;
            end
            ST_TE1, ST_TE2: te_reg <= wrap_once(te_reg);
            ST_W1:
            begin
                // Scaled terms, each divided with truncation toward zero
                half_reg    <= te_reg[ANG_W-1] ?
                               ((37'(te_reg) * 37'sd3) + 37'sd1) >>> 1 :
                               (37'(te_reg) * 37'sd3) >>> 1;
                quarter_reg <= td_reg[ANG_W-1] ?
                               ((38'(td_reg) * 38'sd5) + 38'sd3) >>> 2 :
                               (38'(td_reg) * 38'sd5) >>> 2;
            end
            ST_W2:
            begin
                logic signed [38:0] w;
                logic signed [38:0] wc;
                w  = 39'(half_reg) + 39'(quarter_reg);
                wc = w;
                if (w > 39'(Q_SAT)) wc = 39'(Q_SAT);
                if (w < -39'(Q_SAT)) wc = -39'(Q_SAT);
                tr_reg <= TR_W'((wc + 39'sd65536) >>> 17);
            end
            ST_SP:
            begin
                logic [11:0]        mag;
                logic [23:0]        m;
                logic signed [14:0] sp;
                mag = tr_reg[TR_W-1] ? 12'(-tr_reg) : tr_reg[11:0];
                m   = 24'(mag) * 24'd1229 + 24'd2048;
                sp  = $signed({1'b0, cruise_reg}) - $signed({3'b000, m[23:12]});
                res_tr_reg <= tr_reg;
                res_sp_reg <= ((sp < 0) || (te_reg > Q_HALF_PI)) ? '0 : sp[13:0];
            end
            ST_SQ_WAIT:
            begin
                res_status_reg <= STS_OK;
                res_pe_reg     <= count_reg < NW'(3);
                res_dist_reg   <= best_sum_reg[64] ? 32'hFFFF_FFFF : isq_root;
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg           <= res_status_reg;
            turn_rate_reg        <= res_tr_reg;
            linear_speed_reg     <= res_sp_reg;
            nearest_distance_reg <= res_dist_reg;
            path_ended_reg       <= res_pe_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign turn_rate        = turn_rate_reg;
    assign linear_speed     = linear_speed_reg;
    assign nearest_distance = nearest_distance_reg;
    assign path_ended       = path_ended_reg;

endmodule
